@@ rtl/first_fit_coalescing_allocator_core_defines.svh @@
// assertion macros used by the port-level checker
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_CORE_DEFINES_SVH

// concurrent check clocked on the rising edge, off while reset is high
`define FFCA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ffca check failed");

// concurrent check that also holds while reset is high
`define FFCA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ffca check failed");

`endif

@@ rtl/ffca_pkg.sv @@
// shared constants, codes and types of the free region allocator
package ffca_pkg;

   localparam int MAX_REGIONS = 64;
   localparam int ADDR_W      = 48;
   localparam int COUNT_W     = $clog2(MAX_REGIONS + 1);

   // table operation applied by every cell at the end of a search
   typedef enum logic [2:0] {
      OP_NONE,
      OP_WRITE_SELF,
      OP_WRITE_BELOW,
      OP_INSERT,
      OP_REMOVE,
      OP_MERGE_REMOVE
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NO_FIT  = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   localparam logic [1:0] CSR_HEAP_START  = 2'd0;
   localparam logic [1:0] CSR_HEAP_LENGTH = 2'd1;

   // control broadcast from the sequencer to the row of cells
   typedef struct packed {
      logic              init;
      logic              load;
      logic              step;
      logic              apply;
      op_type            op;
      logic [ADDR_W-1:0] wr_start;
      logic [ADDR_W-1:0] wr_len;
   } ctl_type;

endpackage

@@ rtl/ffca_cell.sv @@
// one free region entry with its scan token, shifting to its neighbors
module ffca_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  ffca_pkg::ctl_type         ctl,
   input  logic                      is_head,
   input  logic [ffca_pkg::ADDR_W-1:0] init_start,
   input  logic [ffca_pkg::ADDR_W-1:0] init_len,
   input  logic                      tok_below,
   input  logic                      tok_above,
   input  logic [ffca_pkg::ADDR_W-1:0] below_start,
   input  logic [ffca_pkg::ADDR_W-1:0] below_len,
   input  logic [ffca_pkg::ADDR_W-1:0] above_start,
   input  logic [ffca_pkg::ADDR_W-1:0] above_len,
   output logic [ffca_pkg::ADDR_W-1:0] start_out,
   output logic [ffca_pkg::ADDR_W-1:0] len_out,
   output logic                      tok_out,
   output logic [ffca_pkg::ADDR_W-1:0] cur_start,
   output logic [ffca_pkg::ADDR_W-1:0] cur_len,
   output logic [ffca_pkg::ADDR_W-1:0] bel_start,
   output logic [ffca_pkg::ADDR_W-1:0] bel_len
);
   import ffca_pkg::*;

   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   logic              tok_ff, tok_in;
   logic              ahead_ff, ahead_in;

   // next entry, token and not-yet-passed flag
   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      tok_in   = tok_ff;
      ahead_in = ahead_ff;
      if (ctl.init) begin
         start_in = init_start;
         len_in   = init_len;
      end else if (ctl.load) begin
         tok_in   = is_head;
         ahead_in = 1'b1;
      end else if (ctl.step) begin
         tok_in   = tok_below;
         ahead_in = ahead_ff & ~tok_ff;
      end else if (ctl.apply) begin
         case (ctl.op)
            OP_WRITE_SELF: begin
               if (tok_ff) begin
                  start_in = ctl.wr_start;
                  len_in   = ctl.wr_len;
               end
            end
            OP_WRITE_BELOW: begin
               if (tok_above) begin
                  start_in = ctl.wr_start;
                  len_in   = ctl.wr_len;
               end
            end
            OP_INSERT: begin
               if (tok_ff) begin
                  start_in = ctl.wr_start;
                  len_in   = ctl.wr_len;
               end else if (ahead_ff) begin
                  start_in = below_start;
                  len_in   = below_len;
               end
            end
            OP_REMOVE: begin
               if (ahead_ff) begin
                  start_in = above_start;
                  len_in   = above_len;
               end
            end
            OP_MERGE_REMOVE: begin
               if (tok_above) begin
                  start_in = ctl.wr_start;
                  len_in   = ctl.wr_len;
               end else if (ahead_ff) begin
                  start_in = above_start;
                  len_in   = above_len;
               end
            end
            default: begin
               start_in = start_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= '0;
         tok_ff   <= 1'b0;
         ahead_ff <= 1'b0;
      end else begin
         start_ff <= start_in;
         len_ff   <= len_in;
         tok_ff   <= tok_in;
         ahead_ff <= ahead_in;
      end
   end

   // neighbor links and the token-selected read ports
   assign start_out = start_ff;
   assign len_out   = len_ff;
   assign tok_out   = tok_ff;
   assign cur_start = tok_ff ? start_ff : '0;
   assign cur_len   = tok_ff ? len_ff : '0;
   assign bel_start = tok_above ? start_ff : '0;
   assign bel_len   = tok_above ? len_ff : '0;

endmodule

@@ rtl/first_fit_coalescing_allocator_core.sv @@
// first-fit free region allocator with coalescing, built as a row of cells
//
//  channel | direction | payload
//  req     | in        | tdata: block_address[47:0], block_length[95:48]; tuser: kind
//  rsp     | out       | tdata: granted_address, free_total, region_count; tuser: status
//  csr     | in        | csr_index selects heap_start (0) or heap_length (1), csr_data
//
// a request walks a token up the row of cells, one region per cycle while no
// heap register write intervenes, until the first fit or the insertion point,
// then updates the table in the apply state; zero-length requests skip the walk.
// the input is ready again in the cycle in which the result is offered.
// reset and every heap register write reload the table with the configured heap.
// a finished result waits in the output register; the update cycle holds while
// an earlier result is still not taken.
module first_fit_coalescing_allocator_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [95:0]   req_tdata,   // block_address, block_length
   input  logic          req_tuser,   // kind
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // granted_address, free_total, region_count, pad
   output logic [1:0]    rsp_tuser,   // status
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [47:0]   csr_data
);
   import ffca_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   heap_start_ff, heap_start_in;
   logic [ADDR_W-1:0]   heap_len_ff, heap_len_in;
   logic [ADDR_W-1:0]   free_ff, free_in;
   logic [COUNT_W-1:0]  used_ff, used_in;
   logic [COUNT_W-1:0]  pos_ff, pos_in;
   logic                kind_ff, kind_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   rlen_ff, rlen_in;
   op_type              op_ff, op_in;
   logic [ADDR_W-1:0]   wr_start_ff, wr_start_in;
   logic [ADDR_W-1:0]   wr_len_ff, wr_len_in;
   status_type          status_ff, status_in;
   logic [ADDR_W-1:0]   granted_ff, granted_in;
   logic                tok_end_ff, tok_end_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [103:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;

   ctl_type             ctl;
   logic                cfg_write;
   logic                req_fire;
   logic                out_free;

   logic [ADDR_W-1:0]   c_start [MAX_REGIONS];
   logic [ADDR_W-1:0]   c_len   [MAX_REGIONS];
   logic                c_tok   [MAX_REGIONS];
   logic [ADDR_W-1:0]   c_cur_s [MAX_REGIONS];
   logic [ADDR_W-1:0]   c_cur_l [MAX_REGIONS];
   logic [ADDR_W-1:0]   c_bel_s [MAX_REGIONS];
   logic [ADDR_W-1:0]   c_bel_l [MAX_REGIONS];

   logic [ADDR_W-1:0]   cur_start, cur_len, bel_start, bel_len;
   logic                cur_valid, at_head, full;
   logic [ADDR_W-1:0]   req_end, below_end;

   // writes to unknown register indexes are taken and ignored
   assign csr_ready  = 1'b1;
   assign cfg_write  = csr_valid
                       && (csr_index == CSR_HEAP_START || csr_index == CSR_HEAP_LENGTH);
   assign req_tready = (state_ff == S_IDLE) && !cfg_write;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // row of cells
   for (genvar j = 0; j < MAX_REGIONS; j++) begin : g_cell
      logic              tb, ta;
      logic [ADDR_W-1:0] bs, bl, as_, al;
      if (j == 0) begin : g_lo
         assign tb = 1'b0;
         assign bs = '0;
         assign bl = '0;
      end else begin : g_mid
         assign tb = c_tok[j-1];
         assign bs = c_start[j-1];
         assign bl = c_len[j-1];
      end
      if (j == MAX_REGIONS - 1) begin : g_hi
         assign ta  = tok_end_ff;
         assign as_ = '0;
         assign al  = '0;
      end else begin : g_low
         assign ta  = c_tok[j+1];
         assign as_ = c_start[j+1];
         assign al  = c_len[j+1];
      end
      ffca_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .is_head     (j == 0),
         .init_start  ((j == 0) ? heap_start_in : '0),
         .init_len    ((j == 0) ? heap_len_in : '0),
         .tok_below   (tb),
         .tok_above   (ta),
         .below_start (bs),
         .below_len   (bl),
         .above_start (as_),
         .above_len   (al),
         .start_out   (c_start[j]),
         .len_out     (c_len[j]),
         .tok_out     (c_tok[j]),
         .cur_start   (c_cur_s[j]),
         .cur_len     (c_cur_l[j]),
         .bel_start   (c_bel_s[j]),
         .bel_len     (c_bel_l[j])
      );
   end

   // gather the token cell and the one below it
   always_comb begin
      cur_start = '0;
      cur_len   = '0;
      bel_start = '0;
      bel_len   = '0;
      for (int j = 0; j < MAX_REGIONS; j++) begin
         cur_start = cur_start | c_cur_s[j];
         cur_len   = cur_len | c_cur_l[j];
         bel_start = bel_start | c_bel_s[j];
         bel_len   = bel_len | c_bel_l[j];
      end
   end

   assign cur_valid = (pos_ff < used_ff);
   assign at_head   = (pos_ff == '0);
   assign full      = (used_ff == COUNT_W'(MAX_REGIONS));
   assign req_end   = addr_ff + rlen_ff;
   assign below_end = bel_start + bel_len;

   // cell control
   always_comb begin
      ctl          = '0;
      ctl.init     = cfg_write;
      ctl.load     = !cfg_write && req_fire;
      ctl.op       = op_ff;
      ctl.wr_start = wr_start_ff;
      ctl.wr_len   = wr_len_ff;
      ctl.apply    = !cfg_write && (state_ff == S_APPLY) && out_free;
      ctl.step     = 1'b0;
      if (!cfg_write && state_ff == S_SCAN) begin
         if (kind_ff == 1'b0)
            ctl.step = cur_valid && (cur_len < rlen_ff);
         else
            ctl.step = cur_valid && !(addr_ff < cur_start);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      heap_start_in = heap_start_ff;
      heap_len_in   = heap_len_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      pos_in        = pos_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      rlen_in       = rlen_ff;
      op_in         = op_ff;
      wr_start_in   = wr_start_ff;
      wr_len_in     = wr_len_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;
      tok_end_in    = tok_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      if (cfg_write) begin
         if (csr_index == CSR_HEAP_START)
            heap_start_in = csr_data;
         else if (csr_index == CSR_HEAP_LENGTH)
            heap_len_in = csr_data;
         free_in = heap_len_in;
         used_in = (heap_len_in != '0) ? COUNT_W'(1) : '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  kind_in    = req_tuser;
                  addr_in    = req_tdata[47:0];
                  rlen_in    = req_tdata[95:48];
                  pos_in     = '0;
                  tok_end_in = 1'b0;
                  op_in      = OP_NONE;
                  status_in  = ST_DONE;
                  granted_in = '0;
                  state_in   = (req_tdata[95:48] == '0) ? S_APPLY : S_SCAN;
               end
            end
            S_SCAN: begin
               if (ctl.step) begin
                  pos_in     = pos_ff + COUNT_W'(1);
                  tok_end_in = c_tok[MAX_REGIONS-1];
               end else begin
                  state_in = S_APPLY;
                  if (kind_ff == 1'b0) begin
                     // first fit found or the table ran out
                     if (!cur_valid) begin
                        status_in = ST_NO_FIT;
                     end else begin
                        granted_in = cur_start;
                        free_in    = free_ff - rlen_ff;
                        if (cur_len == rlen_ff) begin
                           op_in   = OP_REMOVE;
                           used_in = used_ff - COUNT_W'(1);
                        end else begin
                           op_in       = OP_WRITE_SELF;
                           wr_start_in = cur_start + rlen_ff;
                           wr_len_in   = cur_len - rlen_ff;
                        end
                     end
                  end else begin
                     // insertion point reached: merge or insert
                     status_in = ST_DONE;
                     if (!at_head && below_end == addr_ff) begin
                        wr_start_in = bel_start;
                        if (cur_valid && cur_start == req_end) begin
                           op_in     = OP_MERGE_REMOVE;
                           wr_len_in = bel_len + rlen_ff + cur_len;
                           used_in   = used_ff - COUNT_W'(1);
                        end else begin
                           op_in     = OP_WRITE_BELOW;
                           wr_len_in = bel_len + rlen_ff;
                        end
                     end else if (cur_valid && cur_start == req_end) begin
                        op_in       = OP_WRITE_SELF;
                        wr_start_in = addr_ff;
                        wr_len_in   = cur_len + rlen_ff;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        op_in       = OP_INSERT;
                        wr_start_in = addr_ff;
                        wr_len_in   = rlen_ff;
                        used_in     = used_ff + COUNT_W'(1);
                     end
                     // a rejected free leaves the byte count alone
                     if (status_in != ST_FULL)
                        free_in = free_ff + rlen_ff;
                  end
               end
            end
            S_APPLY: begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_user_in  = status_ff;
                  rsp_data_in  = {1'b0, used_ff, free_ff,
                                  (status_ff == ST_DONE) ? granted_ff : '0};
                  state_in     = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         heap_start_ff <= '0;
         heap_len_ff   <= '0;
         free_ff       <= '0;
         used_ff       <= '0;
         tok_end_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         op_ff         <= OP_NONE;
         status_ff     <= ST_DONE;
      end else begin
         state_ff      <= state_in;
         heap_start_ff <= heap_start_in;
         heap_len_ff   <= heap_len_in;
         free_ff       <= free_in;
         used_ff       <= used_in;
         tok_end_ff    <= tok_end_in;
         rsp_valid_ff  <= rsp_valid_in;
         op_ff         <= op_in;
         status_ff     <= status_in;
      end
      pos_ff      <= pos_in;
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      rlen_ff     <= rlen_in;
      wr_start_ff <= wr_start_in;
      wr_len_ff   <= wr_len_in;
      granted_ff  <= granted_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ rtl/ffca_checker.sv @@
// port-level checks of the allocator core, bound to the top level
`include "first_fit_coalescing_allocator_core_defines.svh"

module ffca_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [103:0]  rsp_tdata,
   input logic [1:0]    rsp_tuser
);
   import ffca_pkg::*;

   // a result stays offered until taken
   `FFCA_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   // region count never exceeds the table size
   `FFCA_ASSERT(a_count_max, clock, reset, rsp_tvalid |-> rsp_tdata[102:96] <= COUNT_W'(MAX_REGIONS))
   // a failed request grants no address
   `FFCA_ASSERT(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser != ST_DONE |-> rsp_tdata[47:0] == '0)
   // an accepted request moves the sequencer out of idle, so no input transfer right after one
   `FFCA_ASSERT(a_req_gap, clock, reset, req_tvalid && req_tready |=> !req_tready)
endmodule

bind first_fit_coalescing_allocator_core ffca_checker u_ffca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/first_fit_coalescing_allocator_core_checker.sv @@
// result checker for the free region allocator: mirrors the region table and compares results
module first_fit_coalescing_allocator_core_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [95:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [47:0]  csr_data,
   output int           error_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ffca_pkg::*;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   granted;
      logic [ADDR_W-1:0]   free_total;
      logic [COUNT_W-1:0]  regions;
   } alloc_result_t;

   // mirror of the allocator state
   logic [ADDR_W-1:0]  cfg_start, cfg_length;
   logic [ADDR_W-1:0]  reg_start [MAX_REGIONS];
   logic [ADDR_W-1:0]  reg_len   [MAX_REGIONS];
   int                 used;
   logic [ADDR_W-1:0]  free_bytes;
   alloc_result_t      expected_results[$];

   task automatic reload_table();
      for (int k = 0; k < MAX_REGIONS; k++) begin
         reg_start[k] = '0;
         reg_len[k]   = '0;
      end
      reg_start[0] = cfg_start;
      reg_len[0]   = cfg_length;
      used         = (cfg_length != 0) ? 1 : 0;
      free_bytes   = cfg_length;
   endtask

   function automatic void drop_region(int i);
      for (int k = i; k < used - 1; k++) begin
         reg_start[k] = reg_start[k+1];
         reg_len[k]   = reg_len[k+1];
      end
      used--;
      reg_start[used] = '0;
      reg_len[used]   = '0;
   endfunction

   function automatic bit add_region(int i, logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] l);
      if (used >= MAX_REGIONS) return 0;
      for (int k = used; k > i; k--) begin
         reg_start[k] = reg_start[k-1];
         reg_len[k]   = reg_len[k-1];
      end
      reg_start[i] = s;
      reg_len[i]   = l;
      used++;
      return 1;
   endfunction

   // first fit allocate: returns status, sets the granted address
   function automatic status_type take_block(logic [ADDR_W-1:0] len,
                                             output logic [ADDR_W-1:0] addr);
      int i;
      addr = '0;
      if (len == 0) return ST_DONE;
      for (i = 0; i < used; i++)
         if (reg_len[i] >= len) break;
      if (i >= used) return ST_NO_FIT;
      addr = reg_start[i];
      if (reg_len[i] == len) drop_region(i);
      else begin
         reg_start[i] = reg_start[i] + len;
         reg_len[i]   = reg_len[i] - len;
      end
      free_bytes = free_bytes - len;
      return ST_DONE;
   endfunction

   // ordered insert with merge below, above or both
   function automatic status_type return_block(logic [ADDR_W-1:0] addr,
                                               logic [ADDR_W-1:0] len);
      int i;
      logic [ADDR_W-1:0] fin, below_end;
      if (len == 0) return ST_DONE;
      fin = addr + len;
      for (i = 0; i < used; i++)
         if (addr < reg_start[i]) break;
      if (i == 0) begin
         if (used > 0 && reg_start[0] == fin) begin
            reg_start[0] = addr;
            reg_len[0]   = reg_len[0] + len;
         end else if (!add_region(0, addr, len)) return ST_FULL;
      end else begin
         below_end = reg_start[i-1] + reg_len[i-1];
         if (below_end == addr) begin
            reg_len[i-1] = reg_len[i-1] + len;
            if (i < used && reg_start[i] == fin) begin
               reg_len[i-1] = reg_len[i-1] + reg_len[i];
               drop_region(i);
            end
         end else if (i < used && reg_start[i] == fin) begin
            reg_start[i] = addr;
            reg_len[i]   = reg_len[i] + len;
         end else if (!add_region(i, addr, len)) return ST_FULL;
      end
      free_bytes = free_bytes + len;
      return ST_DONE;
   endfunction

   task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
      error_count++;
      $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
   endtask

   always_comb pending_count = expected_results.size();

   // watch the three channels
   always @(posedge clock) begin
      alloc_result_t exp_r, got_r;
      logic [ADDR_W-1:0] ga;
      if (reset) begin
         cfg_start  = '0;
         cfg_length = '0;
         reload_table();
         expected_results.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEAP_START) cfg_start = csr_data;
            else if (csr_index == CSR_HEAP_LENGTH) cfg_length = csr_data;
            if (csr_index == CSR_HEAP_START || csr_index == CSR_HEAP_LENGTH) reload_table();
         end
         if (rsp_tvalid && rsp_tready) begin
            got_r.status     = status_type'(rsp_tuser);
            got_r.granted    = rsp_tdata[47:0];
            got_r.free_total = rsp_tdata[95:48];
            got_r.regions    = rsp_tdata[102:96];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result transfer", '0, '0);
            end else begin
               exp_r = expected_results.pop_front();
               if (got_r.status != exp_r.status)
                  report_mismatch("status", ADDR_W'(got_r.status), ADDR_W'(exp_r.status));
               if (got_r.granted != exp_r.granted)
                  report_mismatch("granted_address", got_r.granted, exp_r.granted);
               if (got_r.free_total != exp_r.free_total)
                  report_mismatch("free_total", got_r.free_total, exp_r.free_total);
               if (got_r.regions != exp_r.regions)
                  report_mismatch("region_count", ADDR_W'(got_r.regions),
                                  ADDR_W'(exp_r.regions));
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               exp_r.status = return_block(req_tdata[47:0], req_tdata[95:48]);
               ga = '0;
            end else
               exp_r.status = take_block(req_tdata[95:48], ga);
            exp_r.granted    = (exp_r.status == ST_DONE) ? ga : '0;
            exp_r.free_total = free_bytes;
            exp_r.regions    = used[COUNT_W-1:0];
            expected_results.push_back(exp_r);
         end
      end
   end
endmodule

@@ dv/first_fit_coalescing_allocator_core_test.sv @@
// stimulus and verdict for the free region allocator
module first_fit_coalescing_allocator_core_test;
   import ffca_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0, req_tready;
   logic [95:0]  req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid, rsp_tready = 0;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 0, csr_ready;
   logic [1:0]   csr_index = CSR_HEAP_START;
   logic [47:0]  csr_data = '0;
   int           error_count, pending_count;
   int           send_idle_pct = 0, recv_idle_pct = 0;

   // live blocks handed out so far, for well-formed frees
   logic [47:0]  live_addr[$];
   logic [47:0]  live_len[$];
   // lengths and kinds of requests whose results are still to come
   logic [47:0]  last_alloc_len[$];
   bit           rsp_was_alloc[$];

   first_fit_coalescing_allocator_core u_dut (.*);

   first_fit_coalescing_allocator_core_checker u_checker (.*);

   initial forever #10 clock = ~clock;

   // receiver stalls at random
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // collect grants to return them later
   always @(posedge clock) begin
      logic [47:0] alen;
      bit          was_alloc;
      if (!reset && rsp_tvalid && rsp_tready && rsp_was_alloc.size() > 0) begin
         was_alloc = rsp_was_alloc.pop_front();
         alen = '0;
         if (was_alloc && last_alloc_len.size() > 0)
            alen = last_alloc_len.pop_front();
         if (was_alloc && rsp_tuser == ST_DONE && alen != '0 && live_addr.size() < 200) begin
            live_addr.push_back(rsp_tdata[47:0]);
            live_len.push_back(alen);
         end
      end
   end

   task automatic send_item(bit kind, logic [47:0] addr, logic [47:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {len, addr};
      if (kind == 0) last_alloc_len.push_back(len);
      rsp_was_alloc.push_back(kind == 0);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [47:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      live_addr.delete();
      live_len.delete();
      last_alloc_len.delete();
      rsp_was_alloc.delete();
   endtask

   task automatic set_heap(logic [47:0] s, logic [47:0] l);
      drain();
      write_reg(CSR_HEAP_START, s);
      write_reg(CSR_HEAP_LENGTH, l);
   endtask

   // mostly allocate and return granted blocks, some noise
   task automatic random_phase(int count, logic [47:0] max_len);
      int j;
      for (int n = 0; n < count; n++) begin
         j = $urandom_range(99);
         if (j < 45)
            send_item(0, 48'({$urandom, $urandom}), 48'($urandom_range(max_len, 1)));
         else if (j < 85 && live_addr.size() > 0) begin
            j = $urandom_range(live_addr.size() - 1);
            send_item(1, live_addr[j], live_len[j]);
            live_addr.delete(j);
            live_len.delete(j);
         end else if (j < 92)
            send_item(j[0], 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
         else
            send_item(1, 48'($urandom_range(4000)), 48'($urandom_range(8, 1)));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty heap, then extremes
      send_item(0, '0, 48'd1);
      send_item(1, 48'd100, 48'd10);
      send_item(0, '0, 48'd10);
      set_heap(48'h1000, 48'h1000);
      send_item(0, '1, '0);
      send_item(1, '1, '0);
      send_item(0, '0, 48'h2000);
      send_item(0, '0, 48'h100);
      send_item(0, '0, 48'h100);
      send_item(0, '0, 48'h100);
      send_item(1, 48'h1100, 48'h100);
      send_item(1, 48'h1000, 48'h100);
      send_item(1, 48'h1200, 48'h100);
      send_item(0, '0, 48'hd00);
      send_item(0, '0, 48'h300);
      send_item(1, 48'h10, 48'h10);
      send_item(1, '1, '1);
      set_heap('1, '1);
      send_item(0, '0, '1);
      send_item(1, 48'h5, 48'h5);
      // fill the table to hit the full status
      set_heap(48'h0, 48'h400);
      for (int k = 0; k < 64; k++) send_item(0, '0, 48'h8);
      for (int k = 0; k < 66; k++) send_item(1, 48'(k * 16), 48'h8);
      send_idle_pct = 34; recv_idle_pct = 78;
      set_heap(48'h100, 48'h800);
      random_phase(500, 48'h60);
      send_idle_pct = 78; recv_idle_pct = 34;
      set_heap(48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      random_phase(500, 48'hffff);
      send_idle_pct = 0; recv_idle_pct = 0;
      set_heap(48'h0, 48'h200);
      random_phase(500, 48'h20);
      drain();
      if (error_count == 0)
         $display("[first_fit_coalescing_allocator_core] OK");
      else
         $display("[first_fit_coalescing_allocator_core] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[first_fit_coalescing_allocator_core] ERROR");
      $finish;
   end
endmodule

@@ first_fit_coalescing_allocator_core.f @@
+incdir+rtl
rtl/ffca_pkg.sv
rtl/ffca_cell.sv
rtl/first_fit_coalescing_allocator_core.sv
rtl/ffca_checker.sv
dv/first_fit_coalescing_allocator_core_checker.sv
dv/first_fit_coalescing_allocator_core_test.sv
